// File: rtl/core/ohp_pkg.sv
// shared types, constants and helpers of the orientation histogram block
package ohp_pkg;

  localparam int unsigned NUM_BINS    = 36;
  localparam int unsigned BIN_IDX_W   = 6;
  localparam int unsigned CNT_W       = 6;
  localparam int unsigned DIR_W       = 16;
  localparam int unsigned MAG_W       = 16;
  localparam int unsigned WGT_W       = 16;
  localparam int unsigned ANGLE_W     = 9;
  localparam int unsigned SHARE_W     = 11;
  localparam int unsigned PROD_W      = MAG_W + WGT_W;
  localparam int unsigned MUL_B_W     = 16;
  localparam int unsigned MUL_W       = PROD_W + MUL_B_W;
  localparam int unsigned AMT_W       = PROD_W + SHARE_W;
  localparam int unsigned BIN_BASE_W  = 44;

  localparam logic [DIR_W-1:0]     FULL_CIRCLE = 16'd46080;
  localparam logic [SHARE_W-1:0]   BIN_UNITS   = 11'd1280;
  localparam logic [SHARE_W-1:0]   HALF_UNITS  = 11'd640;
  localparam logic [BIN_IDX_W-1:0] LAST_BIN    = 6'd35;
  localparam logic [CNT_W-1:0]     SCAN_END    = 6'd36;
  localparam logic [7:0]           RECIP_FIVE  = 8'd205;

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_WRAP  = 12'b0000_0000_0010,
    ST_DIV   = 12'b0000_0000_0100,
    ST_MUL_P = 12'b0000_0000_1000,
    ST_MUL_O = 12'b0000_0001_0000,
    ST_ADD_O = 12'b0000_0010_0000,
    ST_MUL_N = 12'b0000_0100_0000,
    ST_ADD_N = 12'b0000_1000_0000,
    ST_SCAN  = 12'b0001_0000_0000,
    ST_TEST  = 12'b0010_0000_0000,
    ST_OUT1  = 12'b0100_0000_0000,
    ST_OUT2  = 12'b1000_0000_0000
  } state_e;

  typedef struct packed {
    logic clear;
    logic step;
    logic test;
  } scan_ctl_t;

  typedef struct packed {
    logic [BIN_IDX_W-1:0] idx1;
    logic [BIN_IDX_W-1:0] idx2;
    logic                 dual;
  } peak_t;

  function automatic logic [ANGLE_W-1:0] angle_of(input logic [BIN_IDX_W-1:0] idx);
    logic [ANGLE_W-1:0] ext;
    begin
      ext = ANGLE_W'(idx);
      angle_of = (ext << 3) + (ext << 1);
    end
  endfunction

endpackage

// File: rtl/core/ohp_if.sv
// request and result channel interfaces
interface ohp_in_if;
  import ohp_pkg::*;
  logic             valid;
  logic             ready;
  logic [DIR_W-1:0] direction;
  logic [MAG_W-1:0] magnitude;
  logic [WGT_W-1:0] weight;
  logic             last;

  modport source (output valid, direction, magnitude, weight, last, input ready);
  modport sink   (input valid, direction, magnitude, weight, last, output ready);
endinterface

interface ohp_out_if;
  import ohp_pkg::*;
  logic               valid;
  logic               ready;
  logic [ANGLE_W-1:0] angle_deg;
  logic               is_secondary;
  logic               last_res;

  modport source (output valid, angle_deg, is_secondary, last_res, input ready);
  modport sink   (input valid, angle_deg, is_secondary, last_res, output ready);
endinterface

// File: rtl/core/ohp_bin_mem.sv
// histogram bin memory with per-entry valid bits and registered read
module ohp_bin_mem #(
  parameter int unsigned BinW = 56
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [ohp_pkg::BIN_IDX_W-1:0] rd_addr_i,
  output logic [BinW-1:0]               rd_data_o,
  input  logic                          wr_en_i,
  input  logic [ohp_pkg::BIN_IDX_W-1:0] wr_addr_i,
  input  logic [BinW-1:0]               wr_data_i,
  input  logic                          clr_i
);
  import ohp_pkg::*;

  logic [BinW-1:0]     mem [NUM_BINS];
  logic [NUM_BINS-1:0] valid_q;
  logic [BinW-1:0]     rd_q;
  logic                rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= valid_q[rd_addr_i];
      if (clr_i) begin
        valid_q <= '0;
      end else if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

// File: rtl/core/ohp_peak_scan.sv
// running largest and second-largest bin tracker with the 0.8 ratio test
module ohp_peak_scan #(
  parameter int unsigned BinW = 56
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ohp_pkg::scan_ctl_t            ctl_i,
  input  logic [ohp_pkg::BIN_IDX_W-1:0] idx_i,
  input  logic [BinW-1:0]               value_i,
  output ohp_pkg::peak_t                peak_o
);
  import ohp_pkg::*;

  logic                 have1_q, have1_d, have2_q, have2_d;
  logic [BIN_IDX_W-1:0] i1_q, i1_d, i2_q, i2_d;
  logic [BinW-1:0]      v1_q, v1_d, v2_q, v2_d;
  logic                 dual_q, dual_d;
  logic [BinW+2:0]      five_v2;
  logic [BinW+2:0]      four_v1;

  assign five_v2 = ((BinW+3)'(v2_q) << 2) + (BinW+3)'(v2_q);
  assign four_v1 = (BinW+3)'(v1_q) << 2;

  always_comb begin
    have1_d = have1_q;
    have2_d = have2_q;
    i1_d    = i1_q;
    i2_d    = i2_q;
    v1_d    = v1_q;
    v2_d    = v2_q;
    dual_d  = dual_q;
    if (ctl_i.clear) begin
      have1_d = 1'b0;
      have2_d = 1'b0;
    end else if (ctl_i.step) begin
      if (!have1_q || value_i > v1_q) begin
        if (have1_q) begin
          have2_d = 1'b1;
          i2_d    = i1_q;
          v2_d    = v1_q;
        end
        have1_d = 1'b1;
        i1_d    = idx_i;
        v1_d    = value_i;
      end else if (!have2_q || value_i > v2_q) begin
        have2_d = 1'b1;
        i2_d    = idx_i;
        v2_d    = value_i;
      end
    end
    if (ctl_i.test) begin
      dual_d = have2_q && (five_v2 >= four_v1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have1_q <= 1'b0;
      have2_q <= 1'b0;
      dual_q  <= 1'b0;
    end else begin
      have1_q <= have1_d;
      have2_q <= have2_d;
      dual_q  <= dual_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i1_q <= i1_d;
    i2_q <= i2_d;
    v1_q <= v1_d;
    v2_q <= v2_d;
  end

  assign peak_o.idx1 = i1_q;
  assign peak_o.idx2 = i2_q;
  assign peak_o.dual = dual_q;

endmodule

// File: rtl/core/orientation_histogram_peaks.sv
// orientation histogram top level: sequencer, shared multiplier, bin update
// a sample passes WRAP, DIV, MUL_P, MUL_O, ADD_O, MUL_N and ADD_N before ready
// returns, using the shared multiplier and the bin memory read and write ports
// (two read-modify-writes per sample); a last sample then scans all 36 bins, runs
// the ratio test in TEST and presents 1 or 2 results, the first in OUT1
// async active-low reset empties the histogram and returns the sequencer to idle
module orientation_histogram_peaks #(
  parameter int unsigned SAMPLES_MAX_LOG2 = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  ohp_in_if.sink           req_i,
  ohp_out_if.source        res_o
);
  import ohp_pkg::*;

  localparam int unsigned BinW = BIN_BASE_W + SAMPLES_MAX_LOG2;

  state_e               state_q, state_d;
  logic [DIR_W-1:0]     dir_q, dir_d;
  logic [MAG_W-1:0]     mag_q;
  logic [WGT_W-1:0]     wgt_q;
  logic                 last_q;
  logic [BIN_IDX_W-1:0] own_q, own_d, other_q, other_d;
  logic [SHARE_W-1:0]   share_q, share_d;
  logic [PROD_W-1:0]    prod_q;
  logic [AMT_W-1:0]     amt_q;
  logic [CNT_W-1:0]     cnt_q, cnt_d;

  logic                 in_acc, out_acc;
  logic [7:0]           dir_hi;
  logic [15:0]          recip_prod;
  logic [BIN_IDX_W-1:0] quo;
  logic [DIR_W-1:0]     quo_units;
  logic [SHARE_W-1:0]   rem;

  logic [PROD_W-1:0]    mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [MUL_W-1:0]     mul_res;

  logic [BIN_IDX_W-1:0] rd_addr;
  logic [BinW-1:0]      rd_data;
  logic [BinW:0]        sum;
  logic                 wr_en;
  logic [BIN_IDX_W-1:0] wr_addr;
  logic [BinW-1:0]      wr_data;
  logic                 mem_clr;

  scan_ctl_t            scan_ctl;
  peak_t                peak;

  assign in_acc  = req_i.valid && req_i.ready;
  assign out_acc = res_o.valid && res_o.ready;

  // bin index by reciprocal of five on direction / 256
  assign dir_hi     = dir_q[15:8];
  assign recip_prod = 16'(dir_hi) * 16'(RECIP_FIVE);
  assign quo        = recip_prod[15:10];
  assign quo_units  = (DIR_W'(quo) << 10) + (DIR_W'(quo) << 8);
  assign rem        = SHARE_W'(dir_q - quo_units);

  always_comb begin
    mul_a = PROD_W'(mag_q);
    mul_b = MUL_B_W'(wgt_q);
    case (state_q)
      ST_MUL_O: begin
        mul_a = prod_q;
        mul_b = MUL_B_W'(share_q);
      end
      ST_MUL_N: begin
        mul_a = prod_q;
        mul_b = MUL_B_W'(BIN_UNITS - share_q);
      end
      default: begin
        mul_a = PROD_W'(mag_q);
        mul_b = MUL_B_W'(wgt_q);
      end
    endcase
  end

  assign mul_res = MUL_W'(mul_a) * MUL_W'(mul_b);

  always_comb begin
    case (state_q)
      ST_MUL_O: rd_addr = own_q;
      ST_MUL_N: rd_addr = other_q;
      ST_SCAN:  rd_addr = (cnt_q < SCAN_END) ? cnt_q[BIN_IDX_W-1:0] : '0;
      default:  rd_addr = own_q;
    endcase
  end

  // saturating accumulate
  assign sum     = {1'b0, rd_data} + (BinW+1)'(amt_q);
  assign wr_data = sum[BinW] ? '1 : sum[BinW-1:0];
  assign wr_en   = (state_q == ST_ADD_O) || (state_q == ST_ADD_N);
  assign wr_addr = (state_q == ST_ADD_N) ? other_q : own_q;
  assign mem_clr = out_acc && res_o.last_res;

  always_comb begin
    state_d        = state_q;
    dir_d          = dir_q;
    own_d          = own_q;
    other_d        = other_q;
    share_d        = share_q;
    cnt_d          = cnt_q;
    scan_ctl.clear = 1'b0;
    scan_ctl.step  = 1'b0;
    scan_ctl.test  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          dir_d   = req_i.direction;
          state_d = ST_WRAP;
        end
      end
      ST_WRAP: begin
        if (dir_q >= FULL_CIRCLE) begin
          dir_d = dir_q - FULL_CIRCLE;
        end
        state_d = ST_DIV;
      end
      ST_DIV: begin
        own_d = quo;
        if (rem < HALF_UNITS) begin
          other_d = (quo == '0) ? LAST_BIN : quo - 1'b1;
          share_d = rem + HALF_UNITS;
        end else begin
          other_d = (quo == LAST_BIN) ? '0 : quo + 1'b1;
          share_d = BIN_UNITS + HALF_UNITS - rem;
        end
        state_d = ST_MUL_P;
      end
      ST_MUL_P: state_d = ST_MUL_O;
      ST_MUL_O: state_d = ST_ADD_O;
      ST_ADD_O: state_d = ST_MUL_N;
      ST_MUL_N: state_d = ST_ADD_N;
      ST_ADD_N: begin
        if (last_q) begin
          scan_ctl.clear = 1'b1;
          cnt_d          = '0;
          state_d        = ST_SCAN;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        scan_ctl.step = (cnt_q != '0);
        cnt_d         = cnt_q + 1'b1;
        if (cnt_q == SCAN_END) begin
          state_d = ST_TEST;
        end
      end
      ST_TEST: begin
        scan_ctl.test = 1'b1;
        state_d       = ST_OUT1;
      end
      ST_OUT1: begin
        if (out_acc) begin
          state_d = peak.dual ? ST_OUT2 : ST_IDLE;
        end
      end
      ST_OUT2: begin
        if (out_acc) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (in_acc) begin
        last_q <= req_i.last;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dir_q   <= dir_d;
    own_q   <= own_d;
    other_q <= other_d;
    share_q <= share_d;
    if (in_acc) begin
      mag_q <= req_i.magnitude;
      wgt_q <= req_i.weight;
    end
    if (state_q == ST_MUL_P) begin
      prod_q <= mul_res[PROD_W-1:0];
    end
    if ((state_q == ST_MUL_O) || (state_q == ST_MUL_N)) begin
      amt_q <= mul_res[AMT_W-1:0];
    end
  end

  ohp_bin_mem #(
    .BinW (BinW)
  ) u_bin_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .clr_i     (mem_clr)
  );

  ohp_peak_scan #(
    .BinW (BinW)
  ) u_peak_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (scan_ctl),
    .idx_i   (BIN_IDX_W'(cnt_q - 1'b1)),
    .value_i (rd_data),
    .peak_o  (peak)
  );

  assign req_i.ready        = (state_q == ST_IDLE);
  assign res_o.valid        = (state_q == ST_OUT1) || (state_q == ST_OUT2);
  assign res_o.angle_deg    = angle_of((state_q == ST_OUT2) ? peak.idx2 : peak.idx1);
  assign res_o.is_secondary = (state_q == ST_OUT2);
  assign res_o.last_res     = (state_q == ST_OUT2) || !peak.dual;

endmodule

// File: rtl/core/ohp_checker.sv
// port-level checker for the orientation histogram block and its bind
module ohp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        in_last_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [ohp_pkg::ANGLE_W-1:0] out_angle_i,
  input logic                        out_sec_i,
  input logic                        out_last_i
);
  import ohp_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_angle_i)
      && $stable(out_sec_i) && $stable(out_last_i))
    else $error("result changed while stalled");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i))
    else $error("request taken while a result is pending");

  a_second_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=> out_valid_i && out_sec_i)
    else $error("second peak missing after non-final result");

  a_second_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_sec_i |-> out_last_i)
    else $error("second peak not marked final");

  a_quiet_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !in_last_i |=> !out_valid_i)
    else $error("result after a non-final sample");

endmodule

bind orientation_histogram_peaks ohp_checker u_ohp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .in_last_i   (req_i.last),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_angle_i (res_o.angle_deg),
  .out_sec_i   (res_o.is_secondary),
  .out_last_i  (res_o.last_res)
);

// File: tb/ohp_checker.sv
// checker for the orientation histogram block: predicts peak angles from requests, compares results
module ohp_tb_checker #(
  parameter int unsigned SAMPLES_MAX_LOG2 = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ohp_in_if           req_i,
  ohp_out_if          res_i,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o
);
  import ohp_pkg::*;

  localparam int unsigned BIN_W     = BIN_BASE_W + SAMPLES_MAX_LOG2;
  localparam logic [63:0] BIN_TOP   = (64'd1 << BIN_W) - 64'd1;
  localparam int unsigned DUE_DEPTH = 64;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle_deg;
    logic               is_secondary;
    logic               last_res;
  } orient_t;

  logic [63:0] hist_q [NUM_BINS];
  orient_t     due_mem [DUE_DEPTH];
  int unsigned due_wr, due_rd, due_cnt;
  int unsigned n_fail;

  function automatic logic [63:0] sat_add(input logic [63:0] cur, input logic [63:0] amount);
    if (amount > BIN_TOP - cur) return BIN_TOP;
    return cur + amount;
  endfunction

  task automatic due_add(input orient_t entry);
    if (due_cnt == DUE_DEPTH) begin
      n_fail++;
    end else begin
      due_mem[due_wr] = entry;
      due_wr          = (due_wr + 1) % DUE_DEPTH;
      due_cnt++;
    end
  endtask

  task automatic accumulate_sample(input logic [DIR_W-1:0] dir_raw,
                                   input logic [MAG_W-1:0] mag,
                                   input logic [WGT_W-1:0] wgt);
    int unsigned dir, own, nbr, rem, share;
    logic [63:0] prod;
    dir = dir_raw;
    if (dir >= FULL_CIRCLE) dir = dir - FULL_CIRCLE;
    own = dir / BIN_UNITS;
    rem = dir % BIN_UNITS;
    if (rem < HALF_UNITS) begin
      nbr   = (own == 0) ? NUM_BINS - 1 : own - 1;
      share = rem + HALF_UNITS;
    end else begin
      nbr   = (own == LAST_BIN) ? 0 : own + 1;
      share = BIN_UNITS + HALF_UNITS - rem;
    end
    prod = 64'(mag) * 64'(wgt);
    hist_q[own] = sat_add(hist_q[own], prod * 64'(share));
    hist_q[nbr] = sat_add(hist_q[nbr], prod * 64'(BIN_UNITS - share));
  endtask

  task automatic pick_peaks();
    int unsigned i, top_idx, run_idx;
    logic [63:0] top_val, run_val;
    bit          have_run;
    orient_t     entry;
    top_idx  = 0;
    top_val  = hist_q[0];
    run_idx  = 0;
    run_val  = '0;
    have_run = 1'b0;
    for (i = 1; i < NUM_BINS; i++) begin
      if (hist_q[i] > top_val) begin
        run_idx  = top_idx;
        run_val  = top_val;
        have_run = 1'b1;
        top_idx  = i;
        top_val  = hist_q[i];
      end else if (!have_run || hist_q[i] > run_val) begin
        run_idx  = i;
        run_val  = hist_q[i];
        have_run = 1'b1;
      end
    end
    entry.angle_deg    = ANGLE_W'(top_idx * 10);
    entry.is_secondary = 1'b0;
    if (have_run && 64'd5 * run_val >= 64'd4 * top_val) begin
      entry.last_res = 1'b0;
      due_add(entry);
      entry.angle_deg    = ANGLE_W'(run_idx * 10);
      entry.is_secondary = 1'b1;
      entry.last_res     = 1'b1;
      due_add(entry);
    end else begin
      entry.last_res = 1'b1;
      due_add(entry);
    end
    for (i = 0; i < NUM_BINS; i++) hist_q[i] = '0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    orient_t got, want;
    int unsigned k;
    if (!rst_ni) begin
      for (k = 0; k < NUM_BINS; k++) hist_q[k] = '0;
      due_wr  = 0;
      due_rd  = 0;
      due_cnt = 0;
      n_fail  = 0;
      fail_cnt_o <= 0;
      pending_o  <= 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        got.angle_deg    = res_i.angle_deg;
        got.is_secondary = res_i.is_secondary;
        got.last_res     = res_i.last_res;
        if (due_cnt == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("unexpected result: angle %0d secondary %0b last %0b",
                     got.angle_deg, got.is_secondary, got.last_res);
        end else begin
          want    = due_mem[due_rd];
          due_rd  = (due_rd + 1) % DUE_DEPTH;
          due_cnt--;
          if (got.angle_deg !== want.angle_deg || got.is_secondary !== want.is_secondary ||
              got.last_res !== want.last_res) begin
            n_fail++;
            if (n_fail <= 10)
              $display("result mismatch: expected angle %0d secondary %0b last %0b, %s %0d %s %0b %s %0b",
                       want.angle_deg, want.is_secondary, want.last_res,
                       "got angle", got.angle_deg, "secondary", got.is_secondary,
                       "last", got.last_res);
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        accumulate_sample(req_i.direction, req_i.magnitude, req_i.weight);
        if (req_i.last) pick_peaks();
      end
      fail_cnt_o <= n_fail;
      pending_o  <= due_cnt;
    end
  end

endmodule

// File: tb/tb.sv
// testbench top: drives gradient sample windows into the histogram block and gives the verdict
module tb;
  import ohp_pkg::*;

  localparam int unsigned SAMPLES_LOG2 = 12;
  localparam int unsigned ITEM_GOAL    = 1050;
  localparam int unsigned CALM_AT      = 950;
  localparam int unsigned HOLD_AT      = 300;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned TAIL_CYCLES  = 64;
  localparam int unsigned CYCLE_LIMIT  = 300000;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned sent_cnt = 0;
  int unsigned n_sent = 0;
  int unsigned cycle_cnt = 0;

  ohp_in_if  req_if ();
  ohp_out_if res_if ();

  orientation_histogram_peaks #(
    .SAMPLES_MAX_LOG2(SAMPLES_LOG2)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .res_o (res_if)
  );

  ohp_tb_checker #(
    .SAMPLES_MAX_LOG2(SAMPLES_LOG2)
  ) u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_if),
    .res_i     (res_if),
    .fail_cnt_o(fail_cnt),
    .pending_o (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [DIR_W-1:0] near_center(input int bin_idx, input int spread);
    int d;
    int off;
    off = $urandom_range(0, 2 * spread);
    d   = bin_idx * int'(BIN_UNITS) + int'(HALF_UNITS) + off - spread;
    if (d < 0) d = d + int'(FULL_CIRCLE);
    if (d >= int'(FULL_CIRCLE)) d = d - int'(FULL_CIRCLE);
    return DIR_W'(d);
  endfunction

  task automatic drive_sample(input logic [DIR_W-1:0] dir, input logic [MAG_W-1:0] mag,
                              input logic [WGT_W-1:0] wgt, input logic fin);
    if (n_sent < CALM_AT && $urandom_range(0, 5) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.direction <= dir;
    req_if.magnitude <= mag;
    req_if.weight    <= wgt;
    req_if.last      <= fin;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    n_sent++;
    sent_cnt <= n_sent;
  endtask

  initial begin : receiver
    bit hold_done;
    hold_done = 1'b0;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (!hold_done && sent_cnt >= HOLD_AT) begin
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end else if (sent_cnt < CALM_AT && $urandom_range(0, 2) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end else begin
        res_if.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    int unsigned      kind, len, i, c1, c2, m1, m2;
    bit               pair;
    logic [DIR_W-1:0] dir;
    logic [MAG_W-1:0] mag;
    logic [WGT_W-1:0] wgt;
    rst_ni           <= 1'b0;
    req_if.valid     <= 1'b0;
    req_if.direction <= '0;
    req_if.magnitude <= '0;
    req_if.weight    <= '0;
    req_if.last      <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    drive_sample(16'd0, 16'd0, 16'd0, 1'b1);
    drive_sample(16'd640, 16'hFFFF, 16'hFFFF, 1'b1);
    drive_sample(16'd46079, 16'hFFFF, 16'hFFFF, 1'b0);
    drive_sample(16'd46080, 16'hFFFF, 16'd1, 1'b0);
    drive_sample(16'hFFFF, 16'd1, 16'hFFFF, 1'b0);
    drive_sample(16'd639, 16'd1000, 16'd2000, 1'b0);
    drive_sample(16'd1279, 16'd12345, 16'd54321, 1'b1);
    drive_sample(16'd45500, 16'd40000, 16'd30000, 1'b0);
    drive_sample(16'd100, 16'd40000, 16'd30000, 1'b1);
    drive_sample(near_center(5, 0), 16'd50000, 16'd50000, 1'b0);
    drive_sample(near_center(20, 0), 16'd50000, 16'd50000, 1'b1);
    drive_sample(near_center(20, 0), 16'd50000, 16'd50000, 1'b0);
    drive_sample(near_center(5, 0), 16'd49000, 16'd50000, 1'b1);
    drive_sample(near_center(10, 0), 16'd5, 16'd1, 1'b0);
    drive_sample(near_center(11, 0), 16'd4, 16'd1, 1'b1);
    drive_sample(near_center(12, 0), 16'd5, 16'd1, 1'b0);
    drive_sample(near_center(30, 0), 16'd3, 16'd1, 1'b1);

    while (n_sent < ITEM_GOAL) begin
      kind = $urandom_range(0, 31);
      c1   = $urandom_range(0, NUM_BINS - 1);
      c2   = $urandom_range(0, NUM_BINS - 1);
      if (kind < 20) begin
        len = $urandom_range(1, 24);
        for (i = 1; i <= len; i++) begin
          if ($urandom_range(0, 15) == 0) dir = DIR_W'($urandom);
          else dir = near_center(($urandom_range(0, 2) == 0) ? c2 : c1, $urandom_range(0, 1280));
          drive_sample(dir, MAG_W'($urandom), WGT_W'($urandom), i == len);
        end
      end else if (kind < 24) begin
        len = $urandom_range(1, 10);
        for (i = 1; i <= len; i++)
          drive_sample(DIR_W'($urandom), MAG_W'($urandom), WGT_W'($urandom), i == len);
      end else if (kind < 26) begin
        len = $urandom_range(1, 4);
        for (i = 1; i <= len; i++) begin
          mag = MAG_W'($urandom);
          wgt = WGT_W'($urandom);
          if ($urandom_range(0, 1) == 0) mag = '0;
          else wgt = '0;
          drive_sample(DIR_W'($urandom), mag, wgt, i == len);
        end
      end else if (kind < 28) begin
        mag = MAG_W'($urandom);
        wgt = WGT_W'($urandom);
        drive_sample(near_center(c1, 0), mag, wgt, 1'b0);
        drive_sample(near_center(c2, 0), mag, wgt, 1'b1);
      end else if (kind < 30) begin
        m1  = $urandom_range(1000, 65535);
        m2  = (4 * m1) / 5 + $urandom_range(0, 2) - 1;
        wgt = WGT_W'($urandom);
        drive_sample(near_center(c1, 0), MAG_W'(m1), wgt, 1'b0);
        drive_sample(near_center(c2, 0), MAG_W'(m2), wgt, 1'b1);
      end else begin
        // long heavy windows build large bin sums
        len  = $urandom_range(52, 60);
        pair = $urandom_range(0, 1);
        for (i = 1; i <= len; i++) begin
          drive_sample(near_center(c1, 0), MAG_W'(16'hFFFF - $urandom_range(0, 3)),
                       WGT_W'(16'hFFFF - $urandom_range(0, 3)), (i == len) && !pair);
          if (pair)
            drive_sample(near_center(c2, 0), MAG_W'(16'hFFFF - $urandom_range(0, 3)),
                         WGT_W'(16'hFFFF - $urandom_range(0, 3)), i == len);
        end
      end
    end

    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
